// ----- src/kmds_pkg.sv -----
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared types and constants of the keypad matrix debounce scanner.
// ----------------------------------------------------------------------------
package kmds_pkg;

   localparam int CODE_W   = 7;
   localparam int EVENT_W  = 2;
   localparam int INDEX_W  = 3;
   localparam int THR_W    = 8;
   localparam int PCOUNT_W = 3;
   localparam int CSR_W    = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [EVENT_W-1:0] EVENT_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EVENT_PRESS   = 2'd1;
   localparam logic [EVENT_W-1:0] EVENT_RELEASE = 2'd2;

   localparam logic [CSR_W-1:0] CSR_DEBOUNCE_THRESHOLD = 2'd0;
   localparam logic [CSR_W-1:0] CSR_SCAN_ORDER         = 2'd1;
   localparam logic [CSR_W-1:0] CSR_DEBOUNCE_ENABLE    = 2'd2;

   localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd3;
   localparam logic [THR_W-1:0] COUNT_MAX       = 8'hFF;

   typedef struct packed {
      logic add;
      logic remove;
   } list_op_type;

   typedef struct packed {
      logic listed;
      logic room;
   } list_status_type;

endpackage

// ----- src/kmds_ram.sv -----
// ----------------------------------------------------------------------------
// kmds_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module kmds_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 64
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/kmds_key_state.sv -----
// ----------------------------------------------------------------------------
// kmds_key_state
// Per-key stable level and debounce counter, held in RAM with valid bits
// and a bypass of the latest write.
// ----------------------------------------------------------------------------
module kmds_key_state #(
   parameter int KEYS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   rd_en,
   input  logic [(KEYS > 1 ? $clog2(KEYS) : 1)-1:0] rd_addr,
   input  logic [(KEYS > 1 ? $clog2(KEYS) : 1)-1:0] key,
   input  logic                                   update,
   input  logic                                   key_down,
   input  logic [kmds_pkg::THR_W-1:0]             threshold,
   output logic                                   flip
);
   import kmds_pkg::*;

   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int ENTRY_W = THR_W + 1;

   logic [ENTRY_W-1:0] rd_data;
   logic [KEYS-1:0]    valid_ff;
   logic               wr_vld_ff;
   logic [KEY_W-1:0]   wr_key_ff;
   logic [ENTRY_W-1:0] wr_data_ff;

   logic [ENTRY_W-1:0] cur;
   logic               cur_level;
   logic [THR_W-1:0]   cur_count;
   logic [THR_W-1:0]   inc_count;
   logic [ENTRY_W-1:0] wr_data_in;

   kmds_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEYS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (update),
      .wr_addr (key),
      .wr_data (wr_data_in),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      if (wr_vld_ff && (wr_key_ff == key)) begin
         cur = wr_data_ff;
      end else if (valid_ff[key]) begin
         cur = rd_data;
      end else begin
         cur = '0;
      end
      cur_level = cur[THR_W];
      cur_count = cur[THR_W-1:0];
      inc_count = (cur_count < COUNT_MAX) ? cur_count + 1'b1 : cur_count;
      flip = 1'b0;
      wr_data_in = {cur_level, THR_W'(0)};
      if (key_down != cur_level) begin
         if (inc_count >= threshold) begin
            flip = 1'b1;
            wr_data_in = {key_down, THR_W'(0)};
         end else begin
            wr_data_in = {cur_level, inc_count};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_vld_ff <= 1'b0;
      end else if (update) begin
         valid_ff[key] <= 1'b1;
         wr_vld_ff     <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         wr_key_ff  <= key;
         wr_data_ff <= wr_data_in;
      end
   end

endmodule

// ----- src/kmds_key_list.sv -----
// ----------------------------------------------------------------------------
// kmds_key_list
// List of pressed keycodes: parallel lookup, append and remove with shift.
// ----------------------------------------------------------------------------
module kmds_key_list #(
   parameter int MAX_KEYS = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [kmds_pkg::CODE_W-1:0]           code,
   input  kmds_pkg::list_op_type                 op,
   output kmds_pkg::list_status_type             status,
   output logic [$clog2(MAX_KEYS+1)-1:0]         count_next
);
   import kmds_pkg::*;

   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   logic [CODE_W-1:0] entries_ff [MAX_KEYS];
   logic [CODE_W-1:0] entries_in [MAX_KEYS];
   logic [CODE_W-1:0] above      [MAX_KEYS+1];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [MAX_KEYS-1:0] match;
   logic [MAX_KEYS-1:0] shift;
   logic do_add;
   logic do_rem;

   always_comb begin
      for (int i = 0; i < MAX_KEYS; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (entries_ff[i] == code);
         above[i] = entries_ff[i];
      end
      above[MAX_KEYS] = '0;
      shift[0] = match[0];
      for (int i = 1; i < MAX_KEYS; i++) begin
         shift[i] = shift[i-1] | match[i];
      end
      status.listed = |match;
      status.room   = count_ff < CNT_W'(MAX_KEYS);
      do_add = op.add && status.room && !status.listed;
      do_rem = op.remove && status.listed;
      count_in = count_ff;
      if (do_add) begin
         count_in = count_ff + 1'b1;
      end else if (do_rem) begin
         count_in = count_ff - 1'b1;
      end
      for (int i = 0; i < MAX_KEYS; i++) begin
         entries_in[i] = entries_ff[i];
         if (do_add && (CNT_W'(i) == count_ff)) begin
            entries_in[i] = code;
         end else if (do_rem && shift[i]) begin
            entries_in[i] = above[i+1];
         end
      end
   end

   assign count_next = count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

endmodule

// ----- src/keypad_matrix_debounce_scanner.sv -----
// ----------------------------------------------------------------------------
// keypad_matrix_debounce_scanner
// Debounces sampled keys of a row/column matrix and keeps a pressed list.
//
//   channel  direction  tdata (low bit up)                      tuser
//   req_     in         row_index, col_index, key_down          quick_mode, scan_start
//   rsp_     out        keycode, scan_status, pressed_count     event_kind
//   csr_     in         csr_index selects, csr_data is value    -
//
// one request per cycle while the response side does not stall; a request is
// registered in the input stage, where the key state RAM read lands, then moves
// to the output register.
// a stalled response holds the input stage; a new request is still taken when
// the output register empties in that same cycle.
// reset is synchronous; key state reads as released with a zero counter.
// ----------------------------------------------------------------------------
module keypad_matrix_debounce_scanner #(
   parameter int ROWS     = 8,
   parameter int COLS     = 8,
   parameter int MAX_KEYS = 6
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [7:0]                          req_tdata,  // row_index, col_index, key_down
   input  logic [1:0]                          req_tuser,  // quick_mode, scan_start
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,  // keycode, scan_status, pressed_count
   output logic [1:0]                          rsp_tuser,  // event_kind
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kmds_pkg::CSR_W-1:0]          csr_index,
   input  logic [kmds_pkg::CSR_DATA_W-1:0]     csr_data
);
   import kmds_pkg::*;

   localparam int KEYS  = ROWS * COLS;
   localparam int KEY_W = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int CNT_W = $clog2(MAX_KEYS + 1);

   // configuration
   logic [THR_W-1:0] threshold_ff;
   logic             scan_order_ff;
   logic             debounce_en_ff;

   // input stage
   logic               s1_valid_ff;
   logic [INDEX_W-1:0] s1_row_ff;
   logic [INDEX_W-1:0] s1_col_ff;
   logic               s1_down_ff;
   logic               s1_fast_ff;
   logic               s1_start_ff;

   // output stage
   logic                rsp_valid_ff;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic [EVENT_W-1:0]  rsp_event_ff;
   logic [EVENT_W-1:0]  rsp_status_ff;
   logic [PCOUNT_W-1:0] rsp_count_ff;

   logic [EVENT_W-1:0] scan_event_ff;
   logic [EVENT_W-1:0] scan_event_in;

   logic               req_accept;
   logic               s1_fire;
   logic [INDEX_W-1:0] req_row;
   logic [INDEX_W-1:0] req_col;
   logic [KEY_W-1:0]   rd_key;
   logic [KEY_W-1:0]   s1_key;
   logic               in_range;
   logic [CODE_W-1:0]  code;
   logic [THR_W-1:0]   threshold;
   logic               state_update;
   logic               flip;
   logic               add_req;
   logic               rem_req;
   logic               press;
   logic               release_ev;
   logic [EVENT_W-1:0] event_in;
   list_op_type        list_op;
   list_status_type    list_status;
   logic [CNT_W-1:0]   count_next;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign req_row = req_tdata[2:0];
   assign req_col = req_tdata[5:3];
   assign rd_key  = KEY_W'(int'(req_row) * COLS + int'(req_col));
   assign s1_key  = KEY_W'(int'(s1_row_ff) * COLS + int'(s1_col_ff));

   assign in_range = (int'(s1_row_ff) < ROWS) && (int'(s1_col_ff) < COLS);
   assign code = scan_order_ff ? CODE_W'(int'(s1_col_ff) * ROWS + int'(s1_row_ff) + 1)
                               : CODE_W'(int'(s1_row_ff) * COLS + int'(s1_col_ff) + 1);
   assign threshold    = s1_fast_ff ? THR_W'(0) : threshold_ff;
   assign state_update = s1_fire && in_range && debounce_en_ff;

   kmds_key_state #(
      .KEYS (KEYS)
   ) u_key_state (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_accept),
      .rd_addr   (rd_key),
      .key       (s1_key),
      .update    (state_update),
      .key_down  (s1_down_ff),
      .threshold (threshold),
      .flip      (flip)
   );

   kmds_key_list #(
      .MAX_KEYS (MAX_KEYS)
   ) u_key_list (
      .clock      (clock),
      .reset      (reset),
      .code       (code),
      .op         (list_op),
      .status     (list_status),
      .count_next (count_next)
   );

   always_comb begin
      if (debounce_en_ff) begin
         add_req = in_range && flip && s1_down_ff;
         rem_req = in_range && flip && !s1_down_ff;
      end else begin
         add_req = in_range && s1_down_ff;
         rem_req = in_range && !s1_down_ff;
      end
      press      = add_req && list_status.room && !list_status.listed;
      release_ev = rem_req && (debounce_en_ff || list_status.listed);
      list_op.add    = add_req && s1_fire;
      list_op.remove = rem_req && s1_fire;
      if (press) begin
         event_in = EVENT_PRESS;
      end else if (release_ev) begin
         event_in = EVENT_RELEASE;
      end else begin
         event_in = EVENT_NONE;
      end
      if (event_in != EVENT_NONE) begin
         scan_event_in = event_in;
      end else if (s1_start_ff) begin
         scan_event_in = EVENT_NONE;
      end else begin
         scan_event_in = scan_event_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RESET;
         scan_order_ff  <= 1'b0;
         debounce_en_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DEBOUNCE_THRESHOLD: threshold_ff   <= csr_data;
            CSR_SCAN_ORDER:         scan_order_ff  <= csr_data[0];
            CSR_DEBOUNCE_ENABLE:    debounce_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         scan_event_ff <= EVENT_NONE;
      end else begin
         if (req_accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            rsp_valid_ff  <= 1'b1;
            scan_event_ff <= scan_event_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_ff   <= req_row;
         s1_col_ff   <= req_col;
         s1_down_ff  <= req_tdata[6];
         s1_fast_ff  <= req_tuser[0];
         s1_start_ff <= req_tuser[1];
      end
      if (s1_fire) begin
         rsp_code_ff   <= code;
         rsp_event_ff  <= event_in;
         rsp_status_ff <= scan_event_in;
         rsp_count_ff  <= PCOUNT_W'(count_next);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_count_ff, rsp_status_ff, rsp_code_ff};
   assign rsp_tuser  = rsp_event_ff;

   a_busy_only_when_held: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff)
      else $error("input stage blocked without a held response");

   a_status_follows_event: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != EVENT_NONE) |-> rsp_tdata[8:7] == rsp_tuser)
      else $error("scan status differs from reported event");

   a_press_grows_list: assert property (@(posedge clock) disable iff (reset)
      s1_fire && (event_in == EVENT_PRESS) |-> list_status.room && (count_next != '0))
      else $error("press without list growth");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      s1_fire |-> int'(count_next) <= MAX_KEYS)
      else $error("pressed list overflow");

endmodule

// ----- bench/tb_keypad_matrix_debounce_scanner.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keypad_matrix_debounce_scanner
// Self-checking bench for the keypad matrix debounce scanner.
//
// A short table of key samples covers the register reset values, extreme keys,
// fast scan, scan start, a full pressed list and the release of a key that is
// not listed. After the table come random phases. Each phase writes all three
// registers while the block is idle and then sends bouncing press and release
// runs on a few keys, mixed with stray samples. Every response is checked,
// field by field, against the table or a predictor that keeps its own key state
// and pressed list. Both sides stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_keypad_matrix_debounce_scanner;
   import kmds_pkg::*;

   localparam int KEY_ROWS   = 8;
   localparam int KEY_COLS   = 8;
   localparam int LIST_DEPTH = 6;
   localparam int N_DIRECTED = 22;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
      logic       down;
      logic       fast;
      logic       start;
   } key_sample_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [EVENT_W-1:0]  kev;
      logic [EVENT_W-1:0]  status;
      logic [PCOUNT_W-1:0] count;
   } scan_result_type;

   typedef struct packed {
      key_sample_type  smp;
      logic            typed;
      scan_result_type want;
   } directed_step_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [15:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_W-1:0]      csr_index = CSR_DEBOUNCE_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   keypad_matrix_debounce_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state
   logic [THR_W-1:0]  cfg_threshold;
   logic              cfg_col_major;
   logic              cfg_debounce;
   logic              stable_down [KEY_ROWS*KEY_COLS];
   logic [THR_W-1:0]  bounce_count [KEY_ROWS*KEY_COLS];
   logic [CODE_W-1:0] held_codes [LIST_DEPTH];
   int                held_count;
   logic [EVENT_W-1:0] scan_latest;

   scan_result_type pending_scans [$];
   bit           quiet = 1'b0;
   int           n_sent = 0;
   int           n_seen = 0;
   int           n_press = 0;
   int           n_release = 0;
   int           n_phases = 0;
   int           max_held = 0;
   int           errors = 0;
   int           rsp_stall = 0;

   initial begin
      #1_000_000;
      $display("timeout with %0d responses outstanding", pending_scans.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic void clear_model();
      cfg_threshold = THRESHOLD_RESET;
      cfg_col_major = 1'b0;
      cfg_debounce  = 1'b1;
      foreach (stable_down[k]) begin
         stable_down[k]  = 1'b0;
         bounce_count[k] = '0;
      end
      foreach (held_codes[i]) held_codes[i] = '0;
      held_count  = 0;
      scan_latest = EVENT_NONE;
   endfunction

   function automatic bit is_held(input logic [CODE_W-1:0] code);
      for (int i = 0; i < held_count; i++)
         if (held_codes[i] == code) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit hold_key(input logic [CODE_W-1:0] code);
      if (held_count >= LIST_DEPTH || is_held(code)) return 1'b0;
      held_codes[held_count] = code;
      held_count++;
      return 1'b1;
   endfunction

   function automatic void drop_key(input logic [CODE_W-1:0] code);
      for (int i = 0; i < held_count; i++) begin
         if (held_codes[i] == code) begin
            for (int j = i; j + 1 < held_count; j++) held_codes[j] = held_codes[j+1];
            held_count--;
            return;
         end
      end
   endfunction

   function automatic scan_result_type scan_key(input key_sample_type s);
      scan_result_type  r;
      int               k;
      int               code_i;
      logic [CODE_W-1:0] code;
      logic [THR_W-1:0] limit;
      logic [EVENT_W-1:0] ev;
      code_i = cfg_col_major ? int'(s.col) * KEY_ROWS + int'(s.row) + 1
                             : int'(s.row) * KEY_COLS + int'(s.col) + 1;
      code = code_i[CODE_W-1:0];
      k = int'(s.row) * KEY_COLS + int'(s.col);
      ev = EVENT_NONE;
      if (s.start) scan_latest = EVENT_NONE;
      if (cfg_debounce) begin
         limit = s.fast ? '0 : cfg_threshold;
         if (s.down != stable_down[k]) begin
            if (bounce_count[k] != COUNT_MAX) bounce_count[k]++;
            if (bounce_count[k] >= limit) begin
               stable_down[k]  = s.down;
               bounce_count[k] = '0;
               if (s.down) begin
                  if (hold_key(code)) ev = EVENT_PRESS;
               end else begin
                  drop_key(code);
                  ev = EVENT_RELEASE;
               end
            end
         end else begin
            bounce_count[k] = '0;
         end
      end else if (s.down) begin
         if (hold_key(code)) ev = EVENT_PRESS;
      end else if (is_held(code)) begin
         drop_key(code);
         ev = EVENT_RELEASE;
      end
      if (ev != EVENT_NONE) scan_latest = ev;
      r.code   = code;
      r.kev    = ev;
      r.status = scan_latest;
      r.count  = held_count[PCOUNT_W-1:0];
      return r;
   endfunction

   // response side: random stall bursts
   always @(posedge clock) begin
      if (reset || quiet) begin
         rsp_stall  <= 0;
         rsp_tready <= 1'b1;
      end else if (rsp_stall != 0) begin
         rsp_stall  <= rsp_stall - 1;
         rsp_tready <= (rsp_stall == 1);
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall  <= $urandom_range(1, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_responses
      scan_result_type got;
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.code   = rsp_tdata[6:0];
         got.status = rsp_tdata[8:7];
         got.count  = rsp_tdata[11:9];
         got.kev    = rsp_tuser;
         n_seen++;
         if (got.kev == EVENT_PRESS) n_press++;
         if (got.kev == EVENT_RELEASE) n_release++;
         if (int'(got.count) > max_held) max_held = int'(got.count);
         if (pending_scans.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("response %0d arrived with no request outstanding", n_seen);
         end else begin
            want = pending_scans.pop_front();
            if (got.code !== want.code || got.kev !== want.kev ||
                got.status !== want.status || got.count !== want.count) begin
               errors++;
               if (errors <= 10) begin
                  $display("response %0d: expected code %0d event %0d status %0d count %0d",
                           n_seen, want.code, want.kev, want.status, want.count);
                  $display("response %0d: got code %0d event %0d status %0d count %0d",
                           n_seen, got.code, got.kev, got.status, got.count);
               end
            end
         end
      end
   end

   task automatic send_sample(input key_sample_type s, input logic typed,
                              input scan_result_type want);
      scan_result_type guess;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, s.down, s.col, s.row};
      req_tuser  <= {s.start, s.fast};
      do @(posedge clock); while (!req_tready);
      guess = scan_key(s);
      pending_scans.push_back(typed ? want : guess);
      n_sent++;
   endtask

   task automatic drain();
      while (pending_scans.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input logic [THR_W-1:0] thr, input logic col_major,
                             input logic debounce);
      logic [CSR_DATA_W-1:0] value;
      for (int i = 0; i < 3; i++) begin
         case (i)
            0: begin csr_index <= CSR_DEBOUNCE_THRESHOLD; value = thr; end
            1: begin csr_index <= CSR_SCAN_ORDER; value = {7'd0, col_major}; end
            default: begin csr_index <= CSR_DEBOUNCE_ENABLE; value = {7'd0, debounce}; end
         endcase
         csr_valid <= 1'b1;
         csr_data  <= value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid     <= 1'b0;
      cfg_threshold = thr;
      cfg_col_major = col_major;
      cfg_debounce  = debounce;
      @(posedge clock);
   endtask

   // bouncing press and release runs on a few keys, plus stray samples
   task automatic run_phase(input logic [THR_W-1:0] thr, input logic col_major,
                            input logic debounce, input int budget, input bit hold_mid);
      int          hot_row [10];
      int          hot_col [10];
      bit          hot_down [10];
      int          n_hot;
      int          pick;
      int          len;
      int          sent;
      bit          held;
      bit          lvl;
      key_sample_type s;
      drain();
      set_config(thr, col_major, debounce);
      n_phases++;
      n_hot = $urandom_range(2, 10);
      for (int i = 0; i < n_hot; i++) begin
         hot_row[i]  = $urandom_range(0, KEY_ROWS - 1);
         hot_col[i]  = $urandom_range(0, KEY_COLS - 1);
         hot_down[i] = 1'b0;
      end
      sent = 0;
      held = 1'b0;
      while (sent < budget) begin
         if (hold_mid && !held && sent >= budget / 2) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_scans.size() != 0) @(posedge clock);
            held = 1'b1;
         end
         if ($urandom_range(0, 9) == 0) begin
            s = 9'($urandom);
            send_sample(s, 1'b0, '0);
            sent++;
         end else begin
            pick = $urandom_range(0, n_hot - 1);
            lvl  = ($urandom_range(0, 3) != 0) ? !hot_down[pick] : hot_down[pick];
            if (!debounce) len = $urandom_range(1, 3);
            else case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: len = int'(thr) + 1;
               5, 6:          len = (thr == 0) ? 1 : int'(thr);
               default:       len = $urandom_range(1, int'(thr) + 2);
            endcase
            for (int i = 0; i < len; i++) begin
               s.row   = 3'(hot_row[pick]);
               s.col   = 3'(hot_col[pick]);
               s.down  = ($urandom_range(0, 11) == 0) ? !lvl : lvl;
               s.fast  = ($urandom_range(0, 15) == 0);
               s.start = ($urandom_range(0, 15) == 0);
               send_sample(s, 1'b0, '0);
               sent++;
            end
            hot_down[pick] = lvl;
         end
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   directed_step_type plan [N_DIRECTED] = '{
      '{'{3'd0, 3'd0, 1'b0, 1'b0, 1'b1}, 1'b1, '{7'd1,  EVENT_NONE,    EVENT_NONE,    3'd0}},
      '{'{3'd7, 3'd7, 1'b0, 1'b0, 1'b0}, 1'b1, '{7'd64, EVENT_NONE,    EVENT_NONE,    3'd0}},
      '{'{3'd0, 3'd0, 1'b1, 1'b1, 1'b0}, 1'b1, '{7'd1,  EVENT_PRESS,   EVENT_PRESS,   3'd1}},
      '{'{3'd7, 3'd7, 1'b1, 1'b0, 1'b0}, 1'b1, '{7'd64, EVENT_NONE,    EVENT_PRESS,   3'd1}},
      '{'{3'd7, 3'd7, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{3'd7, 3'd7, 1'b1, 1'b0, 1'b0}, 1'b1, '{7'd64, EVENT_PRESS,   EVENT_PRESS,   3'd2}},
      '{'{3'd3, 3'd5, 1'b1, 1'b0, 1'b1}, 1'b1, '{7'd30, EVENT_NONE,    EVENT_NONE,    3'd2}},
      '{'{3'd3, 3'd5, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{3'd3, 3'd5, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{3'd3, 3'd5, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{3'd1, 3'd2, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{3'd2, 3'd3, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{3'd4, 3'd4, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{'{3'd5, 3'd6, 1'b1, 1'b1, 1'b0}, 1'b1, '{7'd47, EVENT_PRESS,   EVENT_PRESS,   3'd6}},
      '{'{3'd6, 3'd1, 1'b1, 1'b1, 1'b0}, 1'b1, '{7'd50, EVENT_NONE,    EVENT_PRESS,   3'd6}},
      '{'{3'd6, 3'd1, 1'b0, 1'b1, 1'b0}, 1'b1, '{7'd50, EVENT_RELEASE, EVENT_RELEASE, 3'd6}},
      '{'{3'd0, 3'd0, 1'b0, 1'b1, 1'b0}, 1'b1, '{7'd1,  EVENT_RELEASE, EVENT_RELEASE, 3'd5}},
      '{'{3'd0, 3'd0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{'{3'd3, 3'd5, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
      '{'{3'd7, 3'd0, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{3'd0, 3'd7, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{3'd7, 3'd7, 1'b0, 1'b1, 1'b0}, 1'b0, '0}
   };

   initial begin
      clear_model();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: threshold 3, row-major codes, debounce on
      for (int i = 0; i < N_DIRECTED; i++)
         send_sample(plan[i].smp, plan[i].typed, plan[i].want);
      req_tvalid <= 1'b0;
      @(posedge clock);

      run_phase(8'd3,   1'b0, 1'b1, 200, 1'b0);
      run_phase(8'd0,   1'b1, 1'b1, 180, 1'b1);
      run_phase(8'd255, 1'b0, 1'b1, 150, 1'b0);
      run_phase(8'($urandom_range(1, 8)), 1'b1, 1'b0, 180, 1'b0);
      run_phase(8'd1,   1'b0, 1'b0, 150, 1'b0);
      run_phase(8'd2,   1'b1, 1'b1, 120, 1'b0);
      drain();
      quiet = 1'b1;
      run_phase(8'($urandom_range(0, 6)), 1'($urandom_range(0, 1)), 1'b1, 200, 1'b0);

      while (pending_scans.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("%0d requests over %0d register settings, %0d responses checked",
               n_sent, n_phases + 1, n_seen);
      $display("%0d presses and %0d releases reported, up to %0d keys held",
               n_press, n_release, max_held);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
